// ===== sv/xor_checked_frame_parser_core_assert.svh =====
// Assertion macros shared by the frame parser modules.
`ifndef XOR_CHECKED_FRAME_PARSER_CORE_ASSERT_SVH
`define XOR_CHECKED_FRAME_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define XCFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define XCFP_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define XCFP_ASSERT(lbl, clk, rst_n, prop)
`define XCFP_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== sv/xcfp_pkg.sv =====
package xcfp_pkg;

    typedef enum logic [2:0] {
        EV_CONSUMED = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_ACCEPT   = 3'd2,
        EV_FAIL     = 3'd3,
        EV_ACKDROP  = 3'd4,
        EV_REJECT   = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        CFG_REQ_HIGH = 2'd0,
        CFG_REQ_LOW  = 2'd1,
        CFG_ACK_HIGH = 2'd2,
        CFG_ACK_LOW  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] req_high;
        logic [7:0] req_low;
        logic [7:0] ack_high;
        logic [7:0] ack_low;
    } t_hdr_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_cmd;
        logic [7:0] frame_length;
        logic       ack_frame;
    } t_result;

endpackage

// ===== sv/xcfp_parser.sv =====
`include "xor_checked_frame_parser_core_assert.svh"

module xcfp_parser import xcfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_hdr_cfg   i_cfg,
    input  logic       i_beat,
    input  logic [7:0] i_rx_byte,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_HDR_H = 3'd0,
        PH_HDR_L = 3'd1,
        PH_CMD   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHK   = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_xor,   n_xor;
    logic [7:0] r_cnt,   n_cnt;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_cmd,   n_cmd;
    logic       r_resp,  n_resp;

    logic [7:0] rq, ak;
    logic [7:0] cnt_inc;
    logic       resp_out;
    t_event     ev;
    logic [7:0] pbyte, pidx;

    always_comb begin
        n_phase  = r_phase;
        n_xor    = r_xor;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_cmd    = r_cmd;
        n_resp   = r_resp;
        ev       = EV_CONSUMED;
        pbyte    = 8'd0;
        pidx     = 8'd0;
        rq       = (r_phase == PH_HDR_H) ? i_cfg.req_high : i_cfg.req_low;
        ak       = (r_phase == PH_HDR_H) ? i_cfg.ack_high : i_cfg.ack_low;
        cnt_inc  = r_cnt + 8'd1;
        resp_out = r_resp;
        unique case (r_phase)
            PH_HDR_H, PH_HDR_L: begin
                if (i_rx_byte == rq || i_rx_byte == ak) begin
                    n_resp  = (i_rx_byte != rq);
                    n_xor   = r_xor ^ i_rx_byte;
                    n_phase = (r_phase == PH_HDR_H) ? PH_HDR_L : PH_CMD;
                end else begin
                    n_phase = PH_HDR_H;
                    n_xor   = 8'd0;
                    n_cnt   = 8'd0;
                    n_resp  = 1'b0;
                    ev      = EV_REJECT;
                end
                resp_out = n_resp;
            end
            PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_xor   = r_xor ^ i_rx_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_rx_byte;
                n_xor   = r_xor ^ i_rx_byte;
                n_cnt   = 8'd0;
                n_phase = (i_rx_byte == 8'd0) ? PH_CHK : PH_DATA;
            end
            PH_DATA: begin
                ev    = EV_PAYLOAD;
                pbyte = i_rx_byte;
                pidx  = r_cnt;
                n_cnt = cnt_inc;
                n_xor = r_xor ^ i_rx_byte;
                if (cnt_inc == r_len) begin
                    n_phase = PH_CHK;
                end
            end
            PH_CHK: begin
                if (i_rx_byte == r_xor) begin
                    ev = r_resp ? EV_ACKDROP : EV_ACCEPT;
                end else begin
                    ev = EV_FAIL;
                end
                n_phase = PH_HDR_H;
                n_xor   = 8'd0;
                n_cnt   = 8'd0;
                n_resp  = 1'b0;
            end
            default: begin
                n_phase  = PH_HDR_H;
                n_xor    = 8'd0;
                n_cnt    = 8'd0;
                n_resp   = 1'b0;
                resp_out = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_result.event_res     = ev;
        o_result.payload_byte  = pbyte;
        o_result.payload_index = pidx;
        o_result.frame_cmd     = n_cmd;
        o_result.frame_length  = n_len;
        o_result.ack_frame     = resp_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_H;
            r_xor   <= 8'd0;
            r_cnt   <= 8'd0;
            r_len   <= 8'd0;
            r_cmd   <= 8'd0;
            r_resp  <= 1'b0;
        end else if (i_beat) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_resp  <= n_resp;
        end
    end

    `XCFP_ASSERT(a_data_len_nonzero, i_clk, i_rst_n, (r_phase == PH_DATA) |-> (r_len != 8'd0))
    `XCFP_ASSERT(a_idle_clean, i_clk, i_rst_n,
        (r_phase == PH_HDR_H) |-> (r_xor == 8'd0 && r_cnt == 8'd0 && !r_resp))
    `XCFP_ASSERT(a_chk_restarts, i_clk, i_rst_n,
        (i_beat && r_phase == PH_CHK) |=> (r_phase == PH_HDR_H))

endmodule

// ===== sv/xcfp_skid.sv =====
`include "xor_checked_frame_parser_core_assert.svh"

module xcfp_skid import xcfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid, r_skd_valid;
    t_result r_out, r_skd;
    logic    in_beat, out_beat;

    assign o_stall  = r_skd_valid;
    assign in_beat  = i_valid && !r_skd_valid;
    assign out_beat = r_out_valid && !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (out_beat) begin
                r_out       <= r_skd;
                r_skd_valid <= 1'b0;
            end
        end else if (in_beat) begin
            if (!r_out_valid || out_beat) begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skd       <= i_data;
                r_skd_valid <= 1'b1;
            end
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    `XCFP_ASSERT(a_skd_implies_out, i_clk, i_rst_n, r_skd_valid |-> r_out_valid)
    `XCFP_ASSERT(a_out_holds, i_clk, i_rst_n, (r_out_valid && i_stall) |=> r_out_valid)
    `XCFP_ASSERT(a_out_stable, i_clk, i_rst_n, (r_out_valid && i_stall) |=> $stable(r_out))
    `XCFP_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_skd_valid))

endmodule

// ===== sv/xor_checked_frame_parser_core.sv =====
// Byte-stream frame parser with XOR-8 checksum. One received byte is accepted per clock while
// o_in_stall is low, and produces exactly one result beat, registered in the output buffer;
// the only loop is the parse-state update. A two-entry output buffer lets the input keep taking
// bytes while one result waits; o_in_stall rises only when both entries are full. The user must
// see that header patterns are written through the cfg port only while idle; the block does not enforce this.

module xor_checked_frame_parser_core import xcfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_event_res,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic [7:0] o_frame_cmd,
    output logic [7:0] o_frame_length,
    output logic       o_ack_frame
);

    t_hdr_cfg r_cfg;
    t_result  step_res, out_res;
    logic     in_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REQ_HIGH: r_cfg.req_high <= i_cfg_data;
                CFG_REQ_LOW:  r_cfg.req_low  <= i_cfg_data;
                CFG_ACK_HIGH: r_cfg.ack_high <= i_cfg_data;
                CFG_ACK_LOW:  r_cfg.ack_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_beat = i_in_valid && !o_in_stall;

    xcfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_beat    (in_beat),
        .i_rx_byte (i_rx_byte),
        .o_result  (step_res)
    );

    xcfp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (step_res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_event_res     = out_res.event_res;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_frame_cmd     = out_res.frame_cmd;
    assign o_frame_length  = out_res.frame_length;
    assign o_ack_frame     = out_res.ack_frame;

endmodule
